[rtl/pfs_pkg.sv]
package pfs_pkg;

    // Default geometry: 4 KiB pages, 32768 frames.
    localparam int PAGE_BITS_DEF = 12;
    localparam int MAX_PAGES_DEF = 32768;

    // Fixed field widths.
    localparam int ADDR_W   = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int PFREE_W  = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [ADDR_W-1:0] REGION_LOW_RST  = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] REGION_HIGH_RST = 32'h8800_0000;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HIGH = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_FILL  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_BAD   = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_FILL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    pop_issue;
        logic    push_free;
        logic    push_fill;
        logic    fill_init;
        logic    res_set;
        status_t res_status;
        logic    res_load;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  count_zero;
        logic  count_full;
        logic  free_bad;
        logic  fill_more;
        logic  out_busy;
    } stat_t;

endpackage

[rtl/pfs_if.sv]
interface pfs_req_if;
    logic                        valid;
    logic                        ready;
    logic [pfs_pkg::MODE_W-1:0]  mode;
    logic [pfs_pkg::ADDR_W-1:0]  page_addr;

    modport source (output valid, output mode, output page_addr, input ready);
    modport sink   (input valid, input mode, input page_addr, output ready);
endinterface

interface pfs_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pfs_pkg::STATUS_W-1:0] status;
    logic [pfs_pkg::ADDR_W-1:0]   alloc_addr;
    logic [pfs_pkg::PFREE_W-1:0]  pages_free;

    modport source (output valid, output status, output alloc_addr, output pages_free,
                    input ready);
    modport sink   (input valid, input status, input alloc_addr, input pages_free,
                    output ready);
endinterface

[rtl/pfs_ctrl.sv]
module pfs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pfs_pkg::stat_t  stat,
    output pfs_pkg::cmd_t   cmd
);

    pfs_pkg::state_t state_reg;
    pfs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pfs_pkg::S_EXEC;
                end
            end
            pfs_pkg::S_EXEC:
            begin
                case (stat.mode)
                    pfs_pkg::MODE_ALLOC:
                    begin
                        state_next = stat.count_zero ? pfs_pkg::S_DONE : pfs_pkg::S_POP_WAIT;
                    end
                    pfs_pkg::MODE_FILL: state_next = pfs_pkg::S_FILL;
                    default:            state_next = pfs_pkg::S_DONE;
                endcase
            end
            pfs_pkg::S_POP_WAIT: state_next = pfs_pkg::S_DONE;
            pfs_pkg::S_FILL:
            begin
                if (!stat.fill_more || stat.count_full)
                begin
                    state_next = pfs_pkg::S_DONE;
                end
            end
            pfs_pkg::S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = pfs_pkg::S_IDLE;
                end
            end
            default: state_next = pfs_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            pfs_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            pfs_pkg::S_EXEC:
            begin
                case (stat.mode)
                    pfs_pkg::MODE_ALLOC:
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = stat.count_zero ? pfs_pkg::STAT_EMPTY
                                                         : pfs_pkg::STAT_OK;
                        cmd.pop_issue  = !stat.count_zero;
                    end
                    pfs_pkg::MODE_FREE:
                    begin
                        cmd.res_set = 1'b1;
                        if (stat.free_bad)
                        begin
                            cmd.res_status = pfs_pkg::STAT_BAD;
                        end
                        else if (stat.count_full)
                        begin
                            cmd.res_status = pfs_pkg::STAT_FULL;
                        end
                        else
                        begin
                            cmd.res_status = pfs_pkg::STAT_OK;
                            cmd.push_free  = 1'b1;
                        end
                    end
                    pfs_pkg::MODE_FILL:
                    begin
                        cmd.fill_init = 1'b1;
                    end
                    default:
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = pfs_pkg::STAT_OK;
                    end
                endcase
            end
            pfs_pkg::S_FILL:
            begin
                // Stop at the end of the region, or at the first page that does not fit.
                if (!stat.fill_more)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = pfs_pkg::STAT_OK;
                end
                else if (stat.count_full)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = pfs_pkg::STAT_FULL;
                end
                else
                begin
                    cmd.push_fill = 1'b1;
                end
            end
            pfs_pkg::S_DONE:
            begin
                cmd.res_load = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/pfs_datapath.sv]
module pfs_datapath #(
    parameter int PAGE_BITS = pfs_pkg::PAGE_BITS_DEF,
    parameter int MAX_PAGES = pfs_pkg::MAX_PAGES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pfs_pkg::cmd_t                     cmd,
    output pfs_pkg::stat_t                    stat,
    input  logic [pfs_pkg::MODE_W-1:0]        in_mode,
    input  logic [pfs_pkg::ADDR_W-1:0]        in_addr,
    input  logic                              cfg_wr_en,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfs_pkg::ADDR_W-1:0]        cfg_data,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [pfs_pkg::STATUS_W-1:0]      out_status,
    output logic [pfs_pkg::ADDR_W-1:0]        out_alloc_addr,
    output logic [pfs_pkg::PFREE_W-1:0]       out_pages_free
);

    localparam int AW  = pfs_pkg::ADDR_W;
    localparam int PNW = AW - PAGE_BITS;
    localparam int CW  = $clog2(MAX_PAGES + 1);
    localparam int IW  = $clog2(MAX_PAGES);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PAGES);

    logic [AW-1:0]        region_low_reg;
    logic [AW-1:0]        region_high_reg;
    pfs_pkg::mode_t       mode_reg;
    logic [AW-1:0]        addr_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [PNW:0]         cur_pn_reg;
    logic [PNW:0]         cur_pn_next;
    logic                 got_reg;
    pfs_pkg::status_t     res_status_reg;
    logic [PNW-1:0]       rd_data_reg;
    logic                 out_valid_reg;
    logic [pfs_pkg::STATUS_W-1:0] out_status_reg;
    logic [AW-1:0]        out_addr_reg;
    logic [pfs_pkg::PFREE_W-1:0]  out_pfree_reg;

    logic [PNW-1:0]       stack_mem [MAX_PAGES];
    logic                 mem_we;
    logic [IW-1:0]        wr_idx;
    logic [PNW-1:0]       wr_data;
    logic [CW-1:0]        pop_count;
    logic [PNW:0]         start_pn;
    logic [PNW:0]         high_pn;
    logic [AW-1:0]        count_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_low_reg  <= pfs_pkg::REGION_LOW_RST;
            region_high_reg <= pfs_pkg::REGION_HIGH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                pfs_pkg::REG_REGION_LOW:  region_low_reg  <= cfg_data;
                pfs_pkg::REG_REGION_HIGH: region_high_reg <= cfg_data;
                default:                  region_low_reg  <= region_low_reg;
            endcase
        end
    end

    // Page numbers carry one extra bit so the fill walk never wraps.
    assign start_pn = {1'b0, region_low_reg[AW-1:PAGE_BITS]}
                    + (PNW+1)'(|region_low_reg[PAGE_BITS-1:0]);
    assign high_pn  = {1'b0, region_high_reg[AW-1:PAGE_BITS]};
    assign pop_count = count_reg - CW'(1);

    always_comb
    begin
        count_next  = count_reg;
        cur_pn_next = cur_pn_reg;
        mem_we      = cmd.push_free || cmd.push_fill;
        wr_idx      = count_reg[IW-1:0];
        wr_data     = cmd.push_fill ? cur_pn_reg[PNW-1:0] : addr_reg[AW-1:PAGE_BITS];
        if (mem_we)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop_issue)
        begin
            count_next = pop_count;
        end
        if (cmd.fill_init)
        begin
            cur_pn_next = start_pn;
        end
        else if (cmd.push_fill)
        begin
            cur_pn_next = cur_pn_reg + (PNW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_pn_reg <= cur_pn_next;
        if (cmd.capture)
        begin
            mode_reg <= pfs_pkg::mode_t'(in_mode);
            addr_reg <= in_addr;
            got_reg  <= 1'b0;
        end
        else if (cmd.pop_issue)
        begin
            got_reg <= 1'b1;
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop_issue)
        begin
            rd_data_reg <= stack_mem[pop_count[IW-1:0]];
        end
    end

    assign count_wide = AW'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= got_reg ? {rd_data_reg, {PAGE_BITS{1'b0}}} : '0;
            out_pfree_reg  <= count_wide[pfs_pkg::PFREE_W-1:0];
        end
    end

    always_comb
    begin
        stat.mode       = mode_reg;
        stat.count_zero = (count_reg == '0);
        stat.count_full = (count_reg >= COUNT_MAX);
        stat.free_bad   = (|addr_reg[PAGE_BITS-1:0]) || (addr_reg < region_low_reg)
                       || (addr_reg >= region_high_reg);
        stat.fill_more  = (cur_pn_reg < high_pn);
        stat.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_alloc_addr = out_addr_reg;
    assign out_pages_free = out_pfree_reg;

endmodule

[rtl/page_frame_free_stack.sv]
// Channel   Modport   Word fields                        Direction
// req       sink      mode, page_addr                    in
// rsp       source    status, alloc_addr, pages_free     out
//
// Free and unused mode pass the execute and done states before the next acceptance;
// a nonempty alloc adds a pop-wait state: the stack memory read port is registered.
// Fill stays in the fill state for every page pushed, one memory write a cycle.
// Reset clears the page count and presets the region registers; the stack needs no clearing.
// A result waits in the output register while the next word is accepted; a stalled
// result holds the block only when a second result is ready behind it.
module page_frame_free_stack #(
    parameter int PAGE_BITS = pfs_pkg::PAGE_BITS_DEF,
    parameter int MAX_PAGES = pfs_pkg::MAX_PAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    pfs_req_if.sink                        req,
    pfs_rsp_if.source                      rsp,
    input  logic                           cfg_wr_en,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfs_pkg::ADDR_W-1:0]     cfg_data
);

    pfs_pkg::cmd_t  cmd;
    pfs_pkg::stat_t stat;

    pfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfs_datapath #(
        .PAGE_BITS (PAGE_BITS),
        .MAX_PAGES (MAX_PAGES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_mode        (req.mode),
        .in_addr        (req.page_addr),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_status     (rsp.status),
        .out_alloc_addr (rsp.alloc_addr),
        .out_pages_free (rsp.pages_free)
    );

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_free || cmd.push_fill) |-> !stat.count_full)
        else $error("push issued into a full stack");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_issue |-> !stat.count_zero)
        else $error("pop issued from an empty stack");

    a_one_mem_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.push_free, cmd.push_fill, cmd.pop_issue}))
        else $error("more than one stack operation in a cycle");

    a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != pfs_pkg::STAT_OK) |-> (rsp.alloc_addr == '0))
        else $error("nonzero address with an error status");

endmodule

[bench/page_frame_free_stack_test.sv]
module page_frame_free_stack_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W      = pfs_pkg::ADDR_W;
    localparam int PFREE_W     = pfs_pkg::PFREE_W;
    localparam int CFG_IDX_W   = pfs_pkg::CFG_IDX_W;
    localparam int PAGE_SHIFT  = pfs_pkg::PAGE_BITS_DEF;
    localparam int FRAME_SLOTS = pfs_pkg::MAX_PAGES_DEF;
    localparam int PAGE_BYTES  = 1 << PAGE_SHIFT;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        pfs_pkg::mode_t    mode;
        logic [ADDR_W-1:0] addr;
    } request_t;

    typedef struct packed {
        pfs_pkg::status_t   status;
        logic [ADDR_W-1:0]  alloc_addr;
        logic [PFREE_W-1:0] pages_free;
    } result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    pfs_req_if req_ch ();
    pfs_rsp_if rsp_ch ();

    page_frame_free_stack #(
        .PAGE_BITS (PAGE_SHIFT),
        .MAX_PAGES (FRAME_SLOTS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the pool and of the region registers.
    logic [ADDR_W-PAGE_SHIFT-1:0] frame_stack [FRAME_SLOTS];
    int unsigned                  frame_count = 0;
    logic [ADDR_W-1:0]            cfg_low  = pfs_pkg::REGION_LOW_RST;
    logic [ADDR_W-1:0]            cfg_high = pfs_pkg::REGION_HIGH_RST;

    request_t          pending [$];
    result_t           expected_results [$];
    logic [ADDR_W-1:0] lent_pages [$];

    int mismatches    = 0;
    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int send_gap      = 0;
    int take_gap      = 0;
    int cycle_count   = 0;

    always #2 clk = ~clk;

    task automatic pool_step(input pfs_pkg::mode_t mode, input logic [ADDR_W-1:0] addr,
                             output result_t res);
        logic [32:0] p;
        logic [32:0] top;
        logic [32:0] size;
        res.status     = pfs_pkg::STAT_OK;
        res.alloc_addr = '0;
        size = 33'(PAGE_BYTES);
        case (mode)
            pfs_pkg::MODE_ALLOC:
            begin
                if (frame_count == 0)
                begin
                    res.status = pfs_pkg::STAT_EMPTY;
                end
                else
                begin
                    frame_count--;
                    res.alloc_addr = {frame_stack[frame_count], {PAGE_SHIFT{1'b0}}};
                    lent_pages.push_back(res.alloc_addr);
                end
            end
            pfs_pkg::MODE_FREE:
            begin
                if (addr[PAGE_SHIFT-1:0] != '0 || addr < cfg_low || addr >= cfg_high)
                begin
                    res.status = pfs_pkg::STAT_BAD;
                end
                else if (frame_count >= FRAME_SLOTS)
                begin
                    res.status = pfs_pkg::STAT_FULL;
                end
                else
                begin
                    frame_stack[frame_count] = addr[ADDR_W-1:PAGE_SHIFT];
                    frame_count++;
                end
            end
            pfs_pkg::MODE_FILL:
            begin
                // Work in 33 bits so rounding up near the top does not wrap.
                p   = ({1'b0, cfg_low} + size - 33'd1) & ~(size - 33'd1);
                top = {1'b0, cfg_high};
                while (p + size <= top)
                begin
                    if (frame_count >= FRAME_SLOTS)
                    begin
                        res.status = pfs_pkg::STAT_FULL;
                        break;
                    end
                    frame_stack[frame_count] = p[ADDR_W-1:PAGE_SHIFT];
                    frame_count++;
                    p = p + size;
                end
            end
            default:
            begin
            end
        endcase
        res.pages_free = PFREE_W'(frame_count);
    endtask

    // Request driver: a word is predicted at the edge where it is accepted.
    always @(posedge clk)
    begin
        result_t  res;
        request_t rq;
        logic     fire;
        if (rst_n)
        begin
            fire = req_ch.valid && req_ch.ready;
            if (fire)
            begin
                pool_step(pfs_pkg::mode_t'(req_ch.mode), req_ch.page_addr, res);
                expected_results.push_back(res);
                if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
                    send_gap = $urandom_range(1, 8);
            end
            if (!req_ch.valid || fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    rq = pending.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.mode      <= rq.mode;
                    req_ch.page_addr <= rq.addr;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result word: status %0d alloc_addr %h pages_free %0d",
                           rsp_ch.status, rsp_ch.alloc_addr, rsp_ch.pages_free);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.status != want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.alloc_addr != want.alloc_addr)
                    begin
                        $error("alloc_addr: expected %h, actual %h",
                               want.alloc_addr, rsp_ch.alloc_addr);
                        mismatches++;
                    end
                    if (rsp_ch.pages_free != want.pages_free)
                    begin
                        $error("pages_free: expected %0d, actual %0d",
                               want.pages_free, rsp_ch.pages_free);
                        mismatches++;
                    end
                end
            end
            if (take_gap > 0)
            begin
                take_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (take_idle_pct > 0 && $urandom_range(0, 99) < take_idle_pct)
                    take_gap = $urandom_range(1, 8);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic queue_item(input pfs_pkg::mode_t mode, input logic [ADDR_W-1:0] addr);
        request_t rq;
        rq.mode = mode;
        rq.addr = addr;
        pending.push_back(rq);
    endtask

    // Waits until no word is queued, on the bus or owed by the block.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending.size() != 0 || req_ch.valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == pfs_pkg::REG_REGION_LOW)
            cfg_low = data;
        else
            cfg_high = data;
    endtask

    task automatic set_region(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
        wait_drained();
        write_reg(pfs_pkg::REG_REGION_LOW, lo);
        write_reg(pfs_pkg::REG_REGION_HIGH, hi);
        lent_pages.delete();
    endtask

    // An aligned page inside the current region, or a random aligned one if it is empty.
    function automatic logic [ADDR_W-1:0] region_page();
        logic [32:0] base;
        logic [32:0] span;
        int unsigned n;
        base = ({1'b0, cfg_low} + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1);
        if ({1'b0, cfg_high} <= base)
            return $urandom & ~ADDR_W'(PAGE_BYTES - 1);
        span = {1'b0, cfg_high} - base;
        n = int'(span >> PAGE_SHIFT);
        if (n == 0)
            return base[ADDR_W-1:0];
        return base[ADDR_W-1:0] + (ADDR_W'($urandom_range(0, n - 1)) << PAGE_SHIFT);
    endfunction

    // Mostly allocs and legal frees with some fills, noise addresses and the unused mode.
    task automatic queue_mixed(input int count);
        request_t rq;
        int       pick;
        for (int i = 0; i < count; i++)
        begin
            while (pending.size() > 3)
                @(posedge clk);
            pick = $urandom_range(0, 99);
            if (pick < 12)
                rq.mode = pfs_pkg::MODE_FILL;
            else if (pick < 50)
                rq.mode = pfs_pkg::MODE_ALLOC;
            else if (pick < 95)
                rq.mode = pfs_pkg::MODE_FREE;
            else
                rq.mode = pfs_pkg::MODE_NOP;
            rq.addr = $urandom;
            if (rq.mode == pfs_pkg::MODE_FREE)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4 && lent_pages.size() > 0)
                    rq.addr = lent_pages.pop_front();
                else if (pick < 8)
                    rq.addr = region_page();
            end
            pending.push_back(rq);
        end
    endtask

    initial
    begin
        logic [ADDR_W-1:0] lo;
        logic [32:0]       hi;
        int                sel;
        int                pages;

        req_ch.valid     = 1'b0;
        req_ch.mode      = pfs_pkg::MODE_NOP;
        req_ch.page_addr = '0;
        rsp_ch.ready     = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = pfs_pkg::REG_REGION_LOW;
        cfg_data         = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset region: empty pool, bad addresses, then a short push and pop.
        send_idle_pct = 30;
        take_idle_pct = 30;
        queue_item(pfs_pkg::MODE_ALLOC, '0);
        queue_item(pfs_pkg::MODE_NOP, 32'hFFFF_FFFF);
        queue_item(pfs_pkg::MODE_FREE, 32'h8000_0001);
        queue_item(pfs_pkg::MODE_FREE, 32'h7FFF_F000);
        queue_item(pfs_pkg::MODE_FREE, 32'h8800_0000);
        queue_item(pfs_pkg::MODE_FREE, 32'hFFFF_FFFF);
        queue_item(pfs_pkg::MODE_FREE, 32'h8000_0000);
        queue_item(pfs_pkg::MODE_FREE, 32'h87FF_F000);
        queue_item(pfs_pkg::MODE_ALLOC, '0);
        queue_item(pfs_pkg::MODE_ALLOC, '0);

        // Region at address zero, so page zero comes back with an ok status.
        set_region(32'h0000_0000, 32'h0000_3000);
        queue_item(pfs_pkg::MODE_FILL, '0);
        queue_item(pfs_pkg::MODE_ALLOC, '0);
        queue_item(pfs_pkg::MODE_ALLOC, '0);
        queue_item(pfs_pkg::MODE_ALLOC, '0);
        queue_item(pfs_pkg::MODE_ALLOC, '0);
        queue_item(pfs_pkg::MODE_FREE, 32'h0000_0000);

        // Unaligned start is rounded up; the partial page at the top is dropped.
        set_region(32'h0000_1001, 32'h0000_3FFF);
        queue_item(pfs_pkg::MODE_FILL, '0);
        queue_item(pfs_pkg::MODE_FREE, 32'h0000_1000);

        // Top of the address space: the last page would end past 32 bits.
        set_region(32'hFFFF_E000, 32'hFFFF_FFFF);
        queue_item(pfs_pkg::MODE_FILL, '0);
        queue_item(pfs_pkg::MODE_FREE, 32'hFFFF_F000);
        queue_item(pfs_pkg::MODE_ALLOC, '0);

        set_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(pfs_pkg::MODE_FILL, '0);

        set_region(32'h0000_0000, 32'h0000_0000);
        queue_item(pfs_pkg::MODE_FILL, '0);
        queue_item(pfs_pkg::MODE_FREE, 32'h0000_0000);

        // Random regions of a few pages, each phase with its own idle density.
        for (int ph = 0; ph < 8; ph++)
        begin
            lo  = $urandom;
            sel = $urandom_range(0, 3);
            if (sel == 0)
                lo[PAGE_SHIFT-1:0] = '0;
            else if (sel == 1)
                lo = '0;
            pages = $urandom_range(0, 10);
            hi = {1'b0, lo} + 33'(pages * PAGE_BYTES) + 33'($urandom_range(0, PAGE_BYTES - 1));
            if (hi[32])
                hi = 33'h0_FFFF_FFFF;
            if ($urandom_range(0, 7) == 0)
                hi = {1'b0, lo} >> 1;
            set_region(lo, hi[ADDR_W-1:0]);
            sel = $urandom_range(0, 2);
            send_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 15 : 40;
            sel = $urandom_range(0, 2);
            take_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 15 : 40;
            queue_mixed(70);
        end

        // Whole address space: the fill stops at the first page that does not fit.
        set_region(32'h0000_0000, 32'hFFFF_FFFF);
        send_idle_pct = 0;
        take_idle_pct = 0;
        queue_item(pfs_pkg::MODE_FILL, '0);
        queue_item(pfs_pkg::MODE_FREE, 32'h0000_5000);
        queue_item(pfs_pkg::MODE_FILL, '0);
        queue_item(pfs_pkg::MODE_ALLOC, '0);
        queue_item(pfs_pkg::MODE_FREE, 32'h0000_5000);
        queue_mixed(80);

        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
